// ===== design/ltii_pkg.sv =====
package ltii_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int ENTRY_W    = 48;
   localparam int ROW_W      = 2 * ENTRY_W;
   localparam int FRAC_BITS  = 27;

   localparam logic [29:0] LN2_Q30  = 30'd744261118;
   localparam logic [60:0] TERM_SAT = 61'h1000_0000_0000_0000;
   localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

   localparam logic [31:0] INDEX_SCALE_RST = 32'd65536;

   localparam logic CSR_LOG_BASE    = 1'b0;
   localparam logic CSR_INDEX_SCALE = 1'b1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_NORM  = 16'h0002,
      S_SQ    = 16'h0004,
      S_LNMUL = 16'h0008,
      S_LNRND = 16'h0010,
      S_DIFF  = 16'h0020,
      S_POS   = 16'h0040,
      S_IDX   = 16'h0080,
      S_RD0   = 16'h0100,
      S_RD1   = 16'h0200,
      S_RD2   = 16'h0400,
      S_MSET  = 16'h0800,
      S_MUL   = 16'h1000,
      S_RND   = 16'h2000,
      S_ADD   = 16'h4000,
      S_OUT   = 16'h8000
   } state_type;

endpackage

// ===== design/ltii_ram.sv =====
module ltii_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/log_table_interpolated_integral.sv =====
// Channel   | Ports                                   | Transfer
// request   | start, busy, req_*                      | start high while busy low
// response  | rsp_valid, rsp_*                        | one cycle, rsp_valid high
// registers | csr_we, csr_index, csr_wdata            | csr_we high, no wait
//
// A write item leaves busy low, so another item may follow at once.
// A query keeps busy high through, per scale factor, the normalising shifts, one squaring
// step of the log unit per fraction bit, the log-to-index steps, the memory reads and two
// passes of the 48x17 multiplier; the output state then saturates both results.
// The response is shown in the first cycle with busy low again, when a new item may start.
// Reset is synchronous and clears the sequencer and registers; table contents are undefined.
// The response is shown for one cycle and cannot be stalled.
module log_table_interpolated_integral (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [9:0]          req_entry_index,
   input  logic signed [47:0]  req_accel_entry,
   input  logic signed [47:0]  req_vel_entry,
   input  logic [31:0]         req_scale_start,
   input  logic [31:0]         req_scale_end,
   output logic                rsp_valid,
   output logic signed [47:0]  rsp_accel_factor,
   output logic signed [47:0]  rsp_vel_factor,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata
);

   ltii_pkg::state_type state_ff, state_in;

   logic signed [31:0] log_base_ff, log_base_in;
   logic [31:0]        index_scale_ff, index_scale_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_accel_ff, rsp_accel_in;
   logic signed [47:0] rsp_vel_ff, rsp_vel_in;

   logic               sel_ff, sel_in;
   logic               tsel_ff, tsel_in;
   logic [31:0]        xend_ff, xend_in;
   logic [31:0]        m_ff, m_in;
   logic [4:0]         p_ff, p_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [26:0]        frac_ff, frac_in;
   logic [61:0]        lnprod_ff, lnprod_in;
   logic               lnneg_ff, lnneg_in;
   logic signed [31:0] ln_ff, ln_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic [47:0]        umag_ff, umag_in;
   logic               uneg_ff, uneg_in;
   logic               small_ff, small_in;
   logic [ltii_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [47:0]        opa_ff, opa_in;
   logic               opneg_ff, opneg_in;
   logic [ltii_pkg::ROW_W-1:0] lo_ff, lo_in;
   logic [ltii_pkg::ROW_W-1:0] hi_ff, hi_in;
   logic [50:0]        bmag_ff, bmag_in;
   logic               sneg_ff, sneg_in;
   logic signed [47:0] lot_ff, lot_in;
   logic [64:0]        pp_ff, pp_in;
   logic [96:0]        acc_ff, acc_in;
   logic [60:0]        q_ff, q_in;
   logic signed [63:0] res_a_ff, res_a_in;
   logic signed [63:0] res_v_ff, res_v_in;

   logic                       ram_we;
   logic [ltii_pkg::IDX_W-1:0] ram_raddr;
   logic [ltii_pkg::ROW_W-1:0] ram_rdata;

   logic               accept;
   logic [63:0]        sq;
   logic [6:0]         pm31;
   logic signed [33:0] l2;
   logic [33:0]        l2mag;
   logic [62:0]        lnrnd;
   logic [31:0]        lnmag;
   logic signed [32:0] dval;
   logic [32:0]        dabs;
   logic [63:0]        uprod;
   logic [20:0]        iraw;
   logic [ltii_pkg::IDX_W-1:0] iclamp;
   logic signed [47:0] lo_t, hi_t;
   logic signed [48:0] bval;
   logic [48:0]        babs;
   logic [16:0]        chunk;
   logic [96:0]        rnd;
   logic [69:0]        qfull;
   logic signed [63:0] term, val;
   logic signed [63:0] res_sel;
   logic signed [47:0] sat_sel;

   assign accept = start && !busy;
   assign ram_we = accept && (req_func == ltii_pkg::FUNC_WRITE);

   ltii_ram #(
      .WIDTH(ltii_pkg::ROW_W),
      .DEPTH(ltii_pkg::TABLE_SIZE)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(req_entry_index),
      .wdata({req_accel_entry, req_vel_entry}),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      log_base_in    = log_base_ff;
      index_scale_in = index_scale_ff;
      rsp_valid_in   = 1'b0;
      rsp_accel_in   = rsp_accel_ff;
      rsp_vel_in     = rsp_vel_ff;
      sel_in   = sel_ff;
      tsel_in  = tsel_ff;
      xend_in  = xend_ff;
      m_in     = m_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      frac_in  = frac_ff;
      lnprod_in = lnprod_ff;
      lnneg_in = lnneg_ff;
      ln_in    = ln_ff;
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      umag_in  = umag_ff;
      uneg_in  = uneg_ff;
      small_in = small_ff;
      idx_in   = idx_ff;
      opa_in   = opa_ff;
      opneg_in = opneg_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      bmag_in  = bmag_ff;
      sneg_in  = sneg_ff;
      lot_in   = lot_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      res_a_in = res_a_ff;
      res_v_in = res_v_ff;
      ram_raddr = '0;

      sq    = 64'(m_ff) * 64'(m_ff);
      pm31  = 7'({2'b00, p_ff}) - 7'd31;
      l2    = $signed({pm31, 27'd0}) + $signed({7'd0, frac_ff});
      l2mag = l2[33] ? 34'(-l2) : 34'(l2);
      lnrnd = 63'(lnprod_ff) + (63'd1 << 29);
      lnmag = lnrnd[61:30];
      dval  = $signed({ln_ff[31], ln_ff}) - $signed({log_base_ff[31], log_base_ff});
      dabs  = dval[32] ? 33'(-dval) : 33'(dval);
      uprod = 64'(dmag_ff) * 64'(index_scale_ff);
      iraw  = umag_ff[47:27];
      iclamp = (iraw > 21'(ltii_pkg::TABLE_SIZE - 1)) ? ltii_pkg::IDX_W'(ltii_pkg::TABLE_SIZE - 1)
                                                    : iraw[ltii_pkg::IDX_W-1:0];
      lo_t  = tsel_ff ? $signed(lo_ff[47:0]) : $signed(lo_ff[95:48]);
      hi_t  = tsel_ff ? $signed(hi_ff[47:0]) : $signed(hi_ff[95:48]);
      bval  = small_ff ? 49'(lo_t) : (49'(hi_t) - 49'(lo_t));
      babs  = bval[48] ? 49'(-bval) : 49'(bval);
      case (cnt_ff[1:0])
         2'd0:    chunk = bmag_ff[50:34];
         2'd1:    chunk = bmag_ff[33:17];
         2'd2:    chunk = bmag_ff[16:0];
         default: chunk = '0;
      endcase
      rnd   = acc_ff + (97'd1 << (ltii_pkg::FRAC_BITS - 1));
      qfull = rnd[96:27];
      term  = sneg_ff ? -$signed({3'b000, q_ff}) : $signed({3'b000, q_ff});
      val   = term + (small_ff ? 64'sd0 : 64'(lot_ff));
      res_sel = tsel_ff ? res_v_ff : res_a_ff;
      if (res_sel > ltii_pkg::OUT_MAX) begin
         sat_sel = ltii_pkg::OUT_MAX[47:0];
      end else if (res_sel < ltii_pkg::OUT_MIN) begin
         sat_sel = ltii_pkg::OUT_MIN[47:0];
      end else begin
         sat_sel = res_sel[47:0];
      end

      if (csr_we) begin
         case (csr_index)
            ltii_pkg::CSR_LOG_BASE:    log_base_in = $signed(csr_wdata);
            ltii_pkg::CSR_INDEX_SCALE: index_scale_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ltii_pkg::S_IDLE: begin
            if (accept && (req_func == ltii_pkg::FUNC_QUERY)) begin
               m_in    = (req_scale_start == 32'd0) ? 32'd1 : req_scale_start;
               p_in    = 5'd31;
               xend_in = req_scale_end;
               sel_in  = 1'b0;
               tsel_in = 1'b0;
               state_in = ltii_pkg::S_NORM;
            end
         end
         ltii_pkg::S_NORM: begin
            if (m_ff[31]) begin
               cnt_in  = '0;
               frac_in = '0;
               state_in = ltii_pkg::S_SQ;
            end else if (m_ff[31:24] == 8'd0) begin
               m_in = m_ff << 8;
               p_in = p_ff - 5'd8;
            end else begin
               m_in = m_ff << 1;
               p_in = p_ff - 5'd1;
            end
         end
         ltii_pkg::S_SQ: begin
            frac_in = {frac_ff[25:0], sq[63]};
            m_in    = sq[63] ? sq[63:32] : sq[62:31];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ltii_pkg::FRAC_BITS - 1)) begin
               state_in = ltii_pkg::S_LNMUL;
            end
         end
         ltii_pkg::S_LNMUL: begin
            lnprod_in = 62'(l2mag[31:0]) * 62'(ltii_pkg::LN2_Q30);
            lnneg_in  = l2[33];
            state_in  = ltii_pkg::S_LNRND;
         end
         ltii_pkg::S_LNRND: begin
            // Clamp the natural log to the signed 32-bit range.
            if (lnneg_ff) begin
               ln_in = (lnmag > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(lnmag);
            end else begin
               ln_in = (lnmag > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(lnmag);
            end
            state_in = ltii_pkg::S_DIFF;
         end
         ltii_pkg::S_DIFF: begin
            dmag_in  = dabs[31:0];
            dneg_in  = dval[32];
            state_in = ltii_pkg::S_POS;
         end
         ltii_pkg::S_POS: begin
            umag_in  = uprod[63:16];
            uneg_in  = dneg_ff;
            state_in = ltii_pkg::S_IDX;
         end
         ltii_pkg::S_IDX: begin
            // Integer part of 0 or 1, or a negative position, scales entry 0.
            small_in = uneg_ff || (iraw <= 21'd1);
            idx_in   = iclamp;
            if (uneg_ff || (iraw <= 21'd1)) begin
               opa_in   = umag_ff;
               opneg_in = uneg_ff;
            end else begin
               opa_in   = umag_ff - ({38'd0, iclamp} << ltii_pkg::FRAC_BITS);
               opneg_in = 1'b0;
            end
            state_in = ltii_pkg::S_RD0;
         end
         ltii_pkg::S_RD0: begin
            ram_raddr = small_ff ? '0 : (idx_ff - 1'b1);
            state_in  = ltii_pkg::S_RD1;
         end
         ltii_pkg::S_RD1: begin
            ram_raddr = idx_ff;
            lo_in     = ram_rdata;
            state_in  = ltii_pkg::S_RD2;
         end
         ltii_pkg::S_RD2: begin
            hi_in    = ram_rdata;
            state_in = ltii_pkg::S_MSET;
         end
         ltii_pkg::S_MSET: begin
            bmag_in  = {2'b00, babs};
            sneg_in  = opneg_ff ^ bval[48];
            lot_in   = lo_t;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ltii_pkg::S_MUL;
         end
         ltii_pkg::S_MUL: begin
            // Partial products from the top chunk down; each is registered, then added to the accumulator.
            pp_in  = 65'(opa_ff) * 65'(chunk);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               acc_in = (acc_ff << 17) + 97'(pp_ff);
            end
            if (cnt_ff == 5'd3) begin
               state_in = ltii_pkg::S_RND;
            end
         end
         ltii_pkg::S_RND: begin
            q_in     = (qfull > 70'(ltii_pkg::TERM_SAT)) ? ltii_pkg::TERM_SAT : qfull[60:0];
            state_in = ltii_pkg::S_ADD;
         end
         ltii_pkg::S_ADD: begin
            if (!tsel_ff) begin
               res_a_in = sel_ff ? (res_a_ff + val) : -val;
               tsel_in  = 1'b1;
               state_in = ltii_pkg::S_MSET;
            end else begin
               res_v_in = sel_ff ? (res_v_ff + val) : -val;
               if (!sel_ff) begin
                  sel_in  = 1'b1;
                  tsel_in = 1'b0;
                  m_in    = (xend_ff == 32'd0) ? 32'd1 : xend_ff;
                  p_in    = 5'd31;
                  state_in = ltii_pkg::S_NORM;
               end else begin
                  tsel_in  = 1'b0;
                  state_in = ltii_pkg::S_OUT;
               end
            end
         end
         ltii_pkg::S_OUT: begin
            // The acceleration result is saturated first, then velocity.
            if (tsel_ff) begin
               rsp_vel_in   = sat_sel;
               rsp_valid_in = 1'b1;
               tsel_in      = 1'b0;
               state_in     = ltii_pkg::S_IDLE;
            end else begin
               rsp_accel_in = sat_sel;
               tsel_in      = 1'b1;
            end
         end
         default: begin
            state_in = ltii_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ltii_pkg::S_IDLE;
         log_base_ff    <= '0;
         index_scale_ff <= ltii_pkg::INDEX_SCALE_RST;
         rsp_valid_ff   <= 1'b0;
         sel_ff         <= 1'b0;
         tsel_ff        <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         log_base_ff    <= log_base_in;
         index_scale_ff <= index_scale_in;
         rsp_valid_ff   <= rsp_valid_in;
         sel_ff         <= sel_in;
         tsel_ff        <= tsel_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accel_ff <= rsp_accel_in;
      rsp_vel_ff   <= rsp_vel_in;
      xend_ff   <= xend_in;
      m_ff      <= m_in;
      p_ff      <= p_in;
      frac_ff   <= frac_in;
      lnprod_ff <= lnprod_in;
      lnneg_ff  <= lnneg_in;
      ln_ff     <= ln_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      umag_ff   <= umag_in;
      uneg_ff   <= uneg_in;
      small_ff  <= small_in;
      idx_ff    <= idx_in;
      opa_ff    <= opa_in;
      opneg_ff  <= opneg_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      bmag_ff   <= bmag_in;
      sneg_ff   <= sneg_in;
      lot_ff    <= lot_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      res_a_ff  <= res_a_in;
      res_v_ff  <= res_v_in;
   end

   assign busy             = (state_ff != ltii_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accel_factor = rsp_accel_ff;
   assign rsp_vel_factor   = rsp_vel_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for more than one cycle");

   a_strobe_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ltii_pkg::S_OUT))
      else $error("response issued without passing through the output state");

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == ltii_pkg::FUNC_QUERY)) |=> busy)
      else $error("accepted query did not start the sequencer");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == ltii_pkg::FUNC_WRITE)) |=> !busy && !rsp_valid_ff)
      else $error("table write disturbed the sequencer");

   a_square_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ltii_pkg::S_SQ) |-> (cnt_ff <= 5'(ltii_pkg::FRAC_BITS - 1)))
      else $error("squaring counter ran past the last fraction bit");

endmodule
